// File: rtl/swsd_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and width helpers for the sliding-window standard deviation block.
package swsd_pkg;

  localparam int MAX_WINDOW_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int WLEN_W     = 9;
  localparam int WLEN_RESET = 20;
  localparam int SD_W       = 23;
  localparam int FRAC_BITS  = 16;
  localparam logic [SD_W-1:0] SD_MAX = '1;

  // Quotient bits retired per division cycle and root bits per square-root cycle.
  localparam int DIV_STEPS  = 4;
  localparam int SQRT_STEPS = 2;
  localparam int Q_ALIGN    = 4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OLD,
    S_SQ,
    S_SQ2,
    S_MUL1,
    S_MUL2,
    S_NUM,
    S_DIV,
    S_SQRT,
    S_DONE
  } swsd_state_t;

  typedef struct packed {
    logic load;
    logic old;
    logic sq;
    logic sq2;
    logic mul1;
    logic mul2;
    logic num;
    logic div;
    logic sqrt;
    logic out_load;
  } swsd_cmd_t;

  typedef struct packed {
    logic full;
  } swsd_sts_t;

  // Width of the shifted dividend, rounded up so that both iterative units finish evenly.
  function automatic int calc_q_pad(int sb, int mw);
    int w_w;
    int dvd_w;
    w_w   = $clog2(mw + 1);
    dvd_w = 2 * sb + $clog2(mw) + w_w + FRAC_BITS;
    return Q_ALIGN * ((dvd_w + Q_ALIGN - 1) / Q_ALIGN);
  endfunction

endpackage

// File: rtl/swsd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for samples, results and the window length register.
interface swsd_in_if #(
  parameter int SAMPLE_BITS = swsd_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink (input valid, input sample, input restart, output ready);
endinterface

interface swsd_out_if;
  import swsd_pkg::*;
  logic            valid;
  logic            ready;
  logic [SD_W-1:0] std_dev;
  logic            ready_res;

  modport source (output valid, output std_dev, output ready_res, input ready);
  modport sink (input valid, input std_dev, input ready_res, output ready);
endinterface

interface swsd_cfg_if;
  import swsd_pkg::*;
  logic              valid;
  logic              ready;
  logic [WLEN_W-1:0] window_length;

  modport source (output valid, output window_length, input ready);
  modport sink (input valid, input window_length, output ready);
endinterface

// File: rtl/swsd_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
module swsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// File: rtl/swsd_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences the sums, division and square root of one sample.
module swsd_ctrl #(
  parameter int MAX_WINDOW  = swsd_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swsd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  swsd_pkg::swsd_sts_t sts,
  output swsd_pkg::swsd_cmd_t cmd
);
  import swsd_pkg::*;

  localparam int Q_PAD      = calc_q_pad(SAMPLE_BITS, MAX_WINDOW);
  localparam int DIV_ITER   = Q_PAD / DIV_STEPS;
  localparam int SQRT_ITER  = Q_PAD / (2 * SQRT_STEPS);
  localparam int ITER_MAX   = (DIV_ITER > SQRT_ITER) ? DIV_ITER : SQRT_ITER;
  localparam int CNT_W      = $clog2(ITER_MAX + 1);

  swsd_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_OLD;
        end
      end
      S_OLD: begin
        cmd.old   = 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_SQ2;
      end
      S_SQ2: begin
        cmd.sq2   = 1'b1;
        state_nxt = sts.full ? S_MUL1 : S_DONE;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_NUM;
      end
      S_NUM: begin
        cmd.num   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (cnt_r == CNT_W'(DIV_ITER - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SQRT: begin
        cmd.sqrt = 1'b1;
        if (cnt_r == CNT_W'(SQRT_ITER - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_OLD))
    else $error("accepted transaction did not start the sequence");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result presented without a finished computation");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < CNT_W'(DIV_ITER)))
    else $error("division iteration count out of range");
endmodule

// File: rtl/swsd_dp.sv
`timescale 1ns / 1ps
// Datapath with the sample ring, running sums, iterative divider and square root unit.
module swsd_dp #(
  parameter int MAX_WINDOW  = swsd_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swsd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  swsd_pkg::swsd_cmd_t           cmd,
  output swsd_pkg::swsd_sts_t           sts,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_restart,
  input  logic                          cfg_wr,
  input  logic [swsd_pkg::WLEN_W-1:0]   cfg_wlen,
  output logic [swsd_pkg::SD_W-1:0]     out_std_dev,
  output logic                          out_ready_res
);
  import swsd_pkg::*;

  localparam int W_W   = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
  localparam int SQS_W = 2 * SAMPLE_BITS;
  localparam int SQ_W  = 2 * SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int NUM_W = SQ_W + W_W;
  localparam int DEN_W = 2 * W_W;
  localparam int Q_PAD = calc_q_pad(SAMPLE_BITS, MAX_WINDOW);
  localparam int R_W   = Q_PAD / 2;
  localparam int CMP_W = (WLEN_W > W_W) ? WLEN_W : W_W;
  localparam int SAT_W = (R_W > SD_W) ? R_W : SD_W;

  logic [WLEN_W-1:0]             wlen_r;
  logic [CMP_W-1:0]              wlen_ext;
  logic [W_W-1:0]                w;
  logic [PTR_W-1:0]              ptr_r;
  logic [PTR_W-1:0]              ptr_eff;
  logic [W_W-1:0]                fill_r;
  logic signed [SUM_W-1:0]       sum_r;
  logic [SQ_W-1:0]               sq_r;
  logic                          full_r;
  logic                          rdy_r;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SAMPLE_BITS-1:0] old_s;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic signed [SQS_W-1:0]       old_prod;
  logic signed [SQS_W-1:0]       x_prod;
  logic [SQS_W-1:0]              sqt_r;
  logic signed [2*SUM_W-1:0]     sum_prod;
  logic [NUM_W-1:0]              num_r;
  logic [NUM_W-1:0]              sqs_r;
  logic [DEN_W-1:0]              den_r;
  logic [Q_PAD-1:0]              dq_r;
  logic [DEN_W-1:0]              div_rem_r;
  logic [R_W:0]                  sq_rem_r;
  logic [R_W-1:0]                sq_root_r;
  logic [SD_W-1:0]               sd_sat;

  logic [DEN_W-1:0]              dv_rem;
  logic [DEN_W:0]                dv_cur;
  logic [DEN_W:0]                dv_diff;
  logic [Q_PAD-1:0]              dv_q;
  logic [R_W:0]                  sr_rem;
  logic [R_W+2:0]                sr_cur;
  logic [R_W+2:0]                sr_trial;
  logic [R_W+2:0]                sr_diff;
  logic [R_W-1:0]                sr_root;
  logic [Q_PAD-1:0]              sr_opd;

  // Effective window length, clamped to the range the ring supports.
  assign wlen_ext = CMP_W'(wlen_r);
  always_comb begin
    if (wlen_ext < CMP_W'(2)) begin
      w = W_W'(2);
    end else if (wlen_ext > CMP_W'(MAX_WINDOW)) begin
      w = W_W'(MAX_WINDOW);
    end else begin
      w = W_W'(wlen_ext);
    end
  end

  assign ptr_eff  = (in_restart || (W_W'(ptr_r) >= w)) ? '0 : ptr_r;
  assign old_s    = signed'(ram_rdata);
  assign old_prod = old_s * old_s;
  assign x_prod   = x_r * x_r;
  assign sum_prod = sum_r * sum_r;

  swsd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.old),
    .waddr (ptr_r),
    .wdata (x_r),
    .re    (cmd.load),
    .raddr (ptr_eff),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= WLEN_W'(WLEN_RESET);
      ptr_r  <= '0;
      fill_r <= '0;
      sum_r  <= '0;
      sq_r   <= '0;
    end else if (cfg_wr) begin
      wlen_r <= cfg_wlen;
      ptr_r  <= '0;
      fill_r <= '0;
      sum_r  <= '0;
      sq_r   <= '0;
    end else if (cmd.load) begin
      ptr_r <= ptr_eff;
      if (in_restart) begin
        fill_r <= '0;
        sum_r  <= '0;
        sq_r   <= '0;
      end
    end else if (cmd.old) begin
      sum_r  <= sum_r - ((fill_r >= w) ? SUM_W'(old_s) : '0) + SUM_W'(x_r);
      ptr_r  <= ((W_W'(ptr_r) + 1'b1) >= w) ? '0 : PTR_W'(W_W'(ptr_r) + 1'b1);
      fill_r <= (fill_r >= w) ? fill_r : fill_r + 1'b1;
    end else if (cmd.sq) begin
      sq_r <= sq_r - (full_r ? SQ_W'(sqt_r) : '0);
    end else if (cmd.sq2) begin
      sq_r <= sq_r + SQ_W'(sqt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= in_sample;
    end
    if (cmd.old) begin
      full_r <= (fill_r >= w);
      rdy_r  <= (fill_r >= w) || ((fill_r + 1'b1) >= w);
      sqt_r  <= unsigned'(old_prod);
    end
    if (cmd.sq) begin
      sqt_r <= unsigned'(x_prod);
    end
    if (cmd.mul1) begin
      num_r <= NUM_W'(w) * NUM_W'(sq_r);
      den_r <= DEN_W'(w) * DEN_W'(w - 1'b1);
    end
    if (cmd.mul2) begin
      sqs_r <= NUM_W'(unsigned'(sum_prod));
    end
    if (cmd.num) begin
      dq_r      <= Q_PAD'({num_r - sqs_r, {FRAC_BITS{1'b0}}});
      div_rem_r <= '0;
      sq_rem_r  <= '0;
      sq_root_r <= '0;
    end
    if (cmd.div) begin
      dq_r      <= dv_q;
      div_rem_r <= dv_rem;
    end
    if (cmd.sqrt) begin
      dq_r      <= sr_opd;
      sq_rem_r  <= sr_rem;
      sq_root_r <= sr_root;
    end
    if (cmd.out_load) begin
      out_std_dev   <= rdy_r ? sd_sat : '0;
      out_ready_res <= rdy_r;
    end
  end

  // Restoring division, several quotient bits per cycle.
  always_comb begin
    dv_rem  = div_rem_r;
    dv_q    = dq_r;
    dv_cur  = '0;
    dv_diff = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      dv_cur  = {dv_rem, dv_q[Q_PAD-1]};
      dv_q    = {dv_q[Q_PAD-2:0], 1'b0};
      dv_diff = dv_cur - {1'b0, den_r};
      if (dv_cur >= {1'b0, den_r}) begin
        dv_rem  = dv_diff[DEN_W-1:0];
        dv_q[0] = 1'b1;
      end else begin
        dv_rem = dv_cur[DEN_W-1:0];
      end
    end
  end

  // Digit-by-digit integer square root of the quotient, two operand bits per root bit.
  always_comb begin
    sr_rem   = sq_rem_r;
    sr_root  = sq_root_r;
    sr_opd   = dq_r;
    sr_cur   = '0;
    sr_trial = '0;
    sr_diff  = '0;
    for (int i = 0; i < SQRT_STEPS; i++) begin
      sr_cur   = {sr_rem, sr_opd[Q_PAD-1 -: 2]};
      sr_trial = {1'b0, sr_root, 2'b01};
      sr_opd   = {sr_opd[Q_PAD-3:0], 2'b00};
      sr_diff  = sr_cur - sr_trial;
      if (sr_cur >= sr_trial) begin
        sr_rem  = sr_diff[R_W:0];
        sr_root = {sr_root[R_W-2:0], 1'b1};
      end else begin
        sr_rem  = sr_cur[R_W:0];
        sr_root = {sr_root[R_W-2:0], 1'b0};
      end
    end
  end

  assign sd_sat   = (SAT_W'(sq_root_r) > SAT_W'(SD_MAX)) ? SD_MAX : SD_W'(sq_root_r);
  assign sts.full = rdy_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= w)
    else $error("fill count exceeds the window length");

  a_ptr_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.old |=> (W_W'(ptr_r) < w))
    else $error("write pointer left the window");
endmodule

// File: rtl/sliding_window_std_dev.sv
`timescale 1ns / 1ps
// Top level of the sliding-window sample standard deviation block.
// One sample is taken per input transaction and each gives exactly one result transaction.
// While the window is still filling, the result carries ready_res low and std_dev zero, and
// the product, division and square root steps are skipped. Once the window is full, an item
// passes through the running-sum, square and product updates, then a restoring divider that
// retires four quotient bits per cycle, then a square root unit that settles two root bits
// per cycle. The shifted numerator is padded to a multiple of four bits, 68 at the default
// parameters. One item is processed at a time; the result register lets the next sample be
// accepted while a result still waits downstream. A write to window_length clears the
// series, as does a sample with restart set. The sample ring needs no clearing after reset.
module sliding_window_std_dev #(
  parameter int MAX_WINDOW  = swsd_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swsd_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  swsd_in_if.sink     in_ch,
  swsd_out_if.source  out_ch,
  swsd_cfg_if.sink    cfg_ch
);
  import swsd_pkg::*;

  swsd_cmd_t cmd;
  swsd_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  swsd_ctrl #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  swsd_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_sample     (in_ch.sample),
    .in_restart    (in_ch.restart),
    .cfg_wr        (cfg_ch.valid),
    .cfg_wlen      (cfg_ch.window_length),
    .out_std_dev   (out_ch.std_dev),
    .out_ready_res (out_ch.ready_res)
  );
endmodule

// File: tb/sliding_window_std_dev_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sliding-window standard deviation block with its own predictor.
module sliding_window_std_dev_tb;
  import swsd_pkg::*;

  typedef struct packed {
    logic [SD_W-1:0] std_dev;
    logic            ready_res;
  } sd_result_t;

  typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    int              value;
    logic            restart;
    logic            typed;
    logic [SD_W-1:0] std_dev;
    logic            ready_res;
  } stim_row_t;

  localparam int RING_DEPTH  = MAX_WINDOW_DEF;
  localparam int NUM_ROWS    = 22;
  localparam int NUM_PHASES  = 10;
  localparam int IDLE_SETTLE = 12;
  localparam int END_SETTLE  = 60;

  logic clk;
  logic rst_n;

  swsd_in_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) in_if ();
  swsd_out_if out_if ();
  swsd_cfg_if cfg_if ();

  sliding_window_std_dev DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  logic signed [15:0] hist_ring [RING_DEPTH];
  int unsigned        hist_ptr;
  int unsigned        hist_fill;
  logic signed [63:0] run_sum;
  logic [63:0]        run_sumsq;
  logic [WLEN_W-1:0]  win_len_reg;

  sd_result_t expected_q[$];
  sd_result_t exp_head;
  int         err_count;
  bit         idle_on;
  int         stall_left;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic int unsigned eff_len();
    if (win_len_reg < 2) return 2;
    if (win_len_reg > RING_DEPTH) return RING_DEPTH;
    return win_len_reg;
  endfunction

  function automatic void clear_series();
    hist_ptr  = 0;
    hist_fill = 0;
    run_sum   = 0;
    run_sumsq = 0;
  endfunction

  function automatic logic [63:0] square64(logic signed [63:0] v);
    logic [63:0] mag;
    mag = (v < 0) ? -v : v;
    return mag * mag;
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  function automatic sd_result_t stddev_predict(logic signed [15:0] s, logic rs);
    int unsigned        w;
    logic signed [63:0] x;
    logic signed [63:0] oldest;
    logic [63:0]        num;
    logic [63:0]        den;
    logic [63:0]        scaled;
    logic [63:0]        root;
    sd_result_t         res;
    w = eff_len();
    x = s;
    if (rs) clear_series();
    if (hist_ptr >= w) hist_ptr = 0;
    if (hist_fill >= w) begin
      oldest = hist_ring[hist_ptr];
      run_sum   -= oldest;
      run_sumsq -= square64(oldest);
    end else begin
      hist_fill++;
    end
    hist_ring[hist_ptr] = s;
    run_sum   += x;
    run_sumsq += square64(x);
    hist_ptr = (hist_ptr + 1 >= w) ? 0 : hist_ptr + 1;
    res = '0;
    if (hist_fill >= w) begin
      num    = 64'(w) * run_sumsq - square64(run_sum);
      den    = 64'(w) * 64'(w - 1);
      scaled = num << FRAC_BITS;
      root   = floor_root(scaled / den);
      res.std_dev   = (root > SD_MAX) ? SD_MAX : root[SD_W-1:0];
      res.ready_res = 1'b1;
    end
    return res;
  endfunction

  function automatic int rand_sample(int center);
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1, 2, 3: return center + int'($urandom_range(0, 64)) - 32;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  task automatic drive_sample(input logic signed [15:0] s, input logic rs,
                              output sd_result_t pred);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.sample  <= s;
    in_if.restart <= rs;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pred = stddev_predict(s, rs);
  endtask

  task automatic settle_idle();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_window(input logic [WLEN_W-1:0] len);
    settle_idle();
    cfg_if.valid         <= 1'b1;
    cfg_if.window_length <= len;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    win_len_reg = len;
    clear_series();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        err_count++;
        $display("%0t: result transaction with none expected, std_dev %0d, ready_res %0b",
                 $time, out_if.std_dev, out_if.ready_res);
      end else begin
        exp_head = expected_q.pop_front();
        if (out_if.std_dev !== exp_head.std_dev) begin
          err_count++;
          $display("%0t: std_dev mismatch, expected %0d, actual %0d",
                   $time, exp_head.std_dev, out_if.std_dev);
        end
        if (out_if.ready_res !== exp_head.ready_res) begin
          err_count++;
          $display("%0t: ready_res mismatch, expected %0b, actual %0b",
                   $time, exp_head.ready_res, out_if.ready_res);
        end
      end
    end
    if (!idle_on) begin
      stall_left = 0;
      out_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  initial begin
    stim_row_t  rows [NUM_ROWS];
    int         phase_len [NUM_PHASES];
    sd_result_t pred;
    int         w;
    int         n_items;
    int         center;
    logic       rs;
    rows = '{
      '{ROW_SAMPLE, 0,      1'b0, 1'b1, 23'd0,       1'b0},
      '{ROW_SAMPLE, -32768, 1'b1, 1'b1, 23'd0,       1'b0},
      '{ROW_WINDOW, 2,      1'b0, 1'b0, 23'd0,       1'b0},
      '{ROW_SAMPLE, 32767,  1'b0, 1'b1, 23'd0,       1'b0},
      '{ROW_SAMPLE, -32768, 1'b0, 1'b1, 23'd8388607, 1'b1},
      '{ROW_SAMPLE, -32768, 1'b0, 1'b1, 23'd0,       1'b1},
      '{ROW_SAMPLE, 1,      1'b0, 1'b0, 23'd0,       1'b0},
      '{ROW_SAMPLE, 0,      1'b1, 1'b1, 23'd0,       1'b0},
      '{ROW_SAMPLE, 0,      1'b0, 1'b1, 23'd0,       1'b1},
      '{ROW_SAMPLE, 21845,  1'b0, 1'b0, 23'd0,       1'b0},
      '{ROW_SAMPLE, -21846, 1'b0, 1'b0, 23'd0,       1'b0},
      '{ROW_WINDOW, 0,      1'b0, 1'b0, 23'd0,       1'b0},
      '{ROW_SAMPLE, 100,    1'b0, 1'b1, 23'd0,       1'b0},
      '{ROW_SAMPLE, 101,    1'b0, 1'b0, 23'd0,       1'b0},
      '{ROW_WINDOW, 1,      1'b0, 1'b0, 23'd0,       1'b0},
      '{ROW_SAMPLE, 7,      1'b0, 1'b1, 23'd0,       1'b0},
      '{ROW_SAMPLE, 7,      1'b0, 1'b1, 23'd0,       1'b1},
      '{ROW_WINDOW, 3,      1'b0, 1'b0, 23'd0,       1'b0},
      '{ROW_SAMPLE, -5,     1'b0, 1'b1, 23'd0,       1'b0},
      '{ROW_SAMPLE, 5,      1'b0, 1'b1, 23'd0,       1'b0},
      '{ROW_SAMPLE, 0,      1'b0, 1'b1, 23'd1280,    1'b1},
      '{ROW_SAMPLE, 5,      1'b1, 1'b1, 23'd0,       1'b0}
    };
    phase_len = '{2, 256, 3, 1, 20, 7, 0, 100, 511, 50};

    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.sample         <= '0;
    in_if.restart        <= 1'b0;
    cfg_if.valid         <= 1'b0;
    cfg_if.window_length <= '0;
    err_count  = 0;
    idle_on    = 1'b1;
    stall_left = 0;
    win_len_reg = WLEN_W'(WLEN_RESET);
    clear_series();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (rows[i].kind == ROW_WINDOW) begin
        write_window(rows[i].value[WLEN_W-1:0]);
      end else begin
        drive_sample(rows[i].value[15:0], rows[i].restart, pred);
        if (rows[i].typed) expected_q.push_back({rows[i].std_dev, rows[i].ready_res});
        else expected_q.push_back(pred);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) idle_on = 1'b0;
      write_window(WLEN_W'(phase_len[p]));
      w = eff_len();
      n_items = (w < 16) ? 60 : w + 60;
      center = int'($urandom_range(0, 64000)) - 32000;
      for (int k = 0; k < n_items; k++) begin
        rs = ($urandom_range(0, 3 * w) == 0);
        if (rs) center = int'($urandom_range(0, 64000)) - 32000;
        drive_sample(16'(rand_sample(center)), rs, pred);
        expected_q.push_back(pred);
      end
    end

    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (END_SETTLE) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: filelist.f
rtl/swsd_pkg.sv
rtl/swsd_if.sv
rtl/swsd_ram.sv
rtl/swsd_ctrl.sv
rtl/swsd_dp.sv
rtl/sliding_window_std_dev.sv
tb/sliding_window_std_dev_tb.sv
